@@ design/usm_pkg.sv @@
// ---------------------------------------------------------------------------
// usm_pkg
// Shared types, constants and helpers of the UV sphere point generator.
// ---------------------------------------------------------------------------
package usm_pkg;

  // Segment count limits
  localparam logic [8:0] MAX_SEGMENTS = 9'd256;
  localparam logic [8:0] MIN_SEGMENTS = 9'd3;

  // Divider geometry: 17-bit quotient, 9-bit divisor
  localparam int QUO_W = 17;
  localparam int NUM_W = 25;
  localparam int DEN_W = 9;

  // Face mode emits six indices, beat 0..5
  localparam logic [2:0] LAST_BEAT = 3'd5;

  // pi in Q30
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // Register map
  typedef enum logic [2:0] {
    REG_RING_COUNT    = 3'd0,
    REG_SECTION_COUNT = 3'd1,
    REG_SPHERE_RADIUS = 3'd2,
    REG_CENTRE_X      = 3'd3,
    REG_CENTRE_Y      = 3'd4,
    REG_CENTRE_Z      = 3'd5,
    REG_BASE_INDEX    = 3'd6
  } reg_idx_t;

  // Request sideband carried along the pipeline
  typedef struct packed {
    logic        valid;
    logic        mode;
    logic        bad;
    logic [15:0] ps;
    logic [15:0] cs;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
  } side_t;

  // Clamp a count to MIN_SEGMENTS..MAX_SEGMENTS
  function automatic logic [8:0] eff_count(input logic [8:0] c);
    logic [8:0] v;
    v = c;
    if (v > MAX_SEGMENTS) v = MAX_SEGMENTS;
    if (v < MIN_SEGMENTS) v = MIN_SEGMENTS;
    return v;
  endfunction

  // Saturate to signed 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) r = 16'sh7fff;
    else if (v < -20'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  // Quarter-wave sine entry in Q1.14, Taylor series in Q30 (elaboration only)
  function automatic logic [14:0] rom_sin(input int x, input int ab);
    longint unsigned q;
    longint unsigned a;
    longint unsigned a2;
    longint unsigned term;
    longint          sum;
    longint          r;
    q    = 64'd1 << (ab - 2);
    a    = (longint'(x) * PI_Q30 + q) >> (ab - 1);
    a2   = (a * a) >> 30;
    term = a;
    sum  = longint'(a);
    term = ((term * a2) >> 30) / 6;   sum = sum - longint'(term);
    term = ((term * a2) >> 30) / 20;  sum = sum + longint'(term);
    term = ((term * a2) >> 30) / 42;  sum = sum - longint'(term);
    term = ((term * a2) >> 30) / 72;  sum = sum + longint'(term);
    term = ((term * a2) >> 30) / 110; sum = sum - longint'(term);
    term = ((term * a2) >> 30) / 156; sum = sum + longint'(term);
    term = ((term * a2) >> 30) / 210; sum = sum - longint'(term);
    if (sum < 0) sum = 0;
    r = (sum + 32768) >>> 16;
    if (r > 16384) r = 16384;
    return r[14:0];
  endfunction

endpackage

@@ design/usm_div.sv @@
// ---------------------------------------------------------------------------
// usm_div
// Pipelined restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
module usm_div import usm_pkg::*; #(
  parameter int NW = 25,
  parameter int QW = 17,
  parameter int DW = 9
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem_q [0:QW-1];
  logic [QW-1:0] low_q [0:QW-1];
  logic [QW-1:0] quo_q [0:QW-1];

  // One step: shift in a numerator bit, subtract if it fits
  genvar k;
  generate
    for (k = 0; k < QW; k++) begin : g_stage
      logic [DW-1:0] rem_in;
      logic [QW-1:0] low_in;
      logic [QW-1:0] quo_in;
      logic [DW:0]   shifted;
      logic          fits;
      if (k == 0) begin : g_first
        assign rem_in = DW'(num[NW-1:QW]);
        assign low_in = num[QW-1:0];
        assign quo_in = '0;
      end else begin : g_next
        assign rem_in = rem_q[k-1];
        assign low_in = low_q[k-1];
        assign quo_in = quo_q[k-1];
      end
      assign shifted = {rem_in, low_in[QW-1]};
      assign fits    = shifted >= {1'b0, den};
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= fits ? DW'(shifted - {1'b0, den}) : shifted[DW-1:0];
          low_q[k] <= {low_in[QW-2:0], 1'b0};
          quo_q[k] <= {quo_in[QW-2:0], fits};
        end
      end
    end
  endgenerate

  assign quo = quo_q[QW-1];

endmodule

@@ design/usm_trig.sv @@
// ---------------------------------------------------------------------------
// usm_trig
// Sine lookup, unit normal and scaled position, five register stages.
// ---------------------------------------------------------------------------
module usm_trig import usm_pkg::*; #(
  parameter int ANGLE_BITS = 12
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [ANGLE_BITS-1:0] theta,
  input  logic [ANGLE_BITS-1:0] phi,
  input  logic [15:0]           radius,
  input  logic signed [15:0]    cx,
  input  logic signed [15:0]    cy,
  input  logic signed [15:0]    cz,
  output logic signed [15:0]    pos_x,
  output logic signed [15:0]    pos_y,
  output logic signed [15:0]    pos_z,
  output logic signed [15:0]    norm_x,
  output logic signed [15:0]    norm_y,
  output logic signed [15:0]    norm_z
);

  localparam int QN = 1 << (ANGLE_BITS - 2);
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(QN);

  typedef logic [14:0] rom_t [0:QN];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i <= QN; i++) r[i] = rom_sin(i, ANGLE_BITS);
    return r;
  endfunction

  localparam rom_t SIN_ROM = build_rom();

  // Full-turn sine by quadrant symmetry
  function automatic logic signed [15:0] sin_t(input logic [ANGLE_BITS-1:0] t);
    logic [ANGLE_BITS-2:0] x;
    logic [ANGLE_BITS-2:0] idx;
    logic signed [15:0]    v;
    x = {1'b0, t[ANGLE_BITS-3:0]};
    idx = x;
    unique case (t[ANGLE_BITS-1:ANGLE_BITS-2])
      2'd0, 2'd2: idx = x;
      2'd1, 2'd3: idx = (ANGLE_BITS-1)'(QN) - x;
      default:    idx = x;
    endcase
    v = signed'({1'b0, SIN_ROM[idx]});
    if (t[ANGLE_BITS-1]) v = -v;
    return v;
  endfunction

  logic signed [15:0] st, ct, sp, cp;
  logic signed [31:0] pnx, pnz;
  logic signed [15:0] ny2, nx3, ny3, nz3;
  logic signed [32:0] px4, py4, pz4;
  logic signed [15:0] nx4, ny4, nz4;
  logic signed [16:0] rad_s;
  logic signed [31:0] pnx_r, pnz_r;
  logic signed [32:0] px_r, py_r, pz_r;

  assign rad_s = signed'({1'b0, radius});
  assign pnx_r = (pnx + 32'sd8192) >>> 14;
  assign pnz_r = (pnz + 32'sd8192) >>> 14;
  assign px_r  = (px4 + 33'sd8192) >>> 14;
  assign py_r  = (py4 + 33'sd8192) >>> 14;
  assign pz_r  = (pz4 + 33'sd8192) >>> 14;

  always_ff @(posedge clk) begin
    if (en) begin
      // table lookups
      st <= sin_t(theta);
      ct <= sin_t(theta + QUARTER);
      sp <= sin_t(phi);
      cp <= sin_t(phi + QUARTER);
      // ring scaling
      pnx <= st * sp;
      pnz <= ct * sp;
      ny2 <= -cp;
      // normal rounding
      nx3 <= pnx_r[15:0];
      nz3 <= pnz_r[15:0];
      ny3 <= ny2;
      // radius scaling
      px4 <= rad_s * nx3;
      py4 <= rad_s * ny3;
      pz4 <= rad_s * nz3;
      nx4 <= nx3;
      ny4 <= ny3;
      nz4 <= nz3;
      // centre offset and saturation
      pos_x  <= sat16(px_r[19:0] + 20'(cx));
      pos_y  <= sat16(py_r[19:0] + 20'(cy));
      pos_z  <= sat16(pz_r[19:0] + 20'(cz));
      norm_x <= nx4;
      norm_y <= ny4;
      norm_z <= nz4;
    end
  end

endmodule

@@ design/usm_out.sv @@
// ---------------------------------------------------------------------------
// usm_out
// Output holding register and face index sequencer.
// ---------------------------------------------------------------------------
module usm_out import usm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  side_t              side,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [15:0] in_pos_z,
  input  logic signed [15:0] in_norm_x,
  input  logic signed [15:0] in_norm_y,
  input  logic signed [15:0] in_norm_z,
  output logic               adv,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic signed [15:0] pos_z,
  output logic signed [15:0] norm_x,
  output logic signed [15:0] norm_y,
  output logic signed [15:0] norm_z,
  output logic [16:0]        tex_u,
  output logic [16:0]        tex_v,
  output logic [15:0]        vertex_index,
  output logic               last,
  output logic               bad_request
);

  logic        hv;
  logic        hmode;
  logic        hbad;
  logic [2:0]  beat;
  logic [15:0] ps, ps1, cs1, cs;
  logic [15:0] sel;
  logic        zero_geo;

  assign zero_geo = side.mode | side.bad;
  assign last     = hbad | ~hmode | (beat == LAST_BEAT);
  assign adv      = ~hv | (out_ready & last);

  // Holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      hv   <= 1'b0;
      beat <= '0;
    end else if (adv) begin
      hv   <= side.valid;
      beat <= '0;
    end else if (out_ready) begin
      beat <= beat + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hmode  <= side.mode;
      hbad   <= side.bad;
      ps     <= side.ps;
      ps1    <= side.ps + 16'd1;
      cs     <= side.cs;
      cs1    <= side.cs + 16'd1;
      pos_x  <= zero_geo ? '0 : in_pos_x;
      pos_y  <= zero_geo ? '0 : in_pos_y;
      pos_z  <= zero_geo ? '0 : in_pos_z;
      norm_x <= zero_geo ? '0 : in_norm_x;
      norm_y <= zero_geo ? '0 : in_norm_y;
      norm_z <= zero_geo ? '0 : in_norm_z;
      tex_u  <= zero_geo ? '0 : side.tex_u;
      tex_v  <= zero_geo ? '0 : side.tex_v;
    end
  end

  // Triangle order: C+s, P+s, C+s+1, C+s+1, P+s, P+s+1
  always_comb begin
    unique case (beat)
      3'd0:       sel = cs;
      3'd1:       sel = ps;
      3'd2, 3'd3: sel = cs1;
      3'd4:       sel = ps;
      3'd5:       sel = ps1;
      default:    sel = '0;
    endcase
  end

  assign out_valid    = hv;
  assign vertex_index = (hmode & ~hbad) ? sel : '0;
  assign bad_request  = hbad;

`ifndef SYNTHESIS
  a_beat_range: assert property (@(posedge clk) disable iff (rst)
    hv |-> beat <= LAST_BEAT)
    else $error("face beat counter out of range");

  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    (hv && (!hmode || hbad)) |-> beat == 3'd0)
    else $error("single-result request advanced beat");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (hv && hbad) |-> (tex_u == '0 && pos_x == '0 && vertex_index == '0))
    else $error("flagged result carries data");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !hv)
    else $error("output holds a result after reset");
`endif

endmodule

@@ design/uv_sphere_mesh_point_generator_top.sv @@
// Pipeline: 1 input stage, 17 divider stages, 5 trig stages, 1 output
// register. Throughput: one vertex request per cycle unless out_ready stalls;
// an in-range face request holds the output register for six results, set
// by the index sequencer.
// Reset (rst, synchronous): empties the pipeline, loads register defaults.
// ---------------------------------------------------------------------------
// uv_sphere_mesh_point_generator_top
// UV sphere vertex and quad index generator, fully pipelined.
// ---------------------------------------------------------------------------
module uv_sphere_mesh_point_generator_top import usm_pkg::*; #(
  parameter int ANGLE_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  logic [7:0]         ring,
  input  logic [8:0]         section,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic signed [15:0] pos_z,
  output logic signed [15:0] norm_x,
  output logic signed [15:0] norm_y,
  output logic signed [15:0] norm_z,
  output logic [16:0]        tex_u,
  output logic [16:0]        tex_v,
  output logic [15:0]        vertex_index,
  output logic               last,
  output logic               bad_request
);

  localparam int TRIG_LAT = 5;

  logic [8:0]         ring_count, section_count;
  logic [15:0]        sphere_radius, base_index;
  logic signed [15:0] centre_x, centre_y, centre_z;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_count    <= 9'd16;
      section_count <= 9'd16;
      sphere_radius <= 16'd256;
      centre_x      <= '0;
      centre_y      <= '0;
      centre_z      <= '0;
      base_index    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RING_COUNT:    ring_count    <= cfg_data[8:0];
        REG_SECTION_COUNT: section_count <= cfg_data[8:0];
        REG_SPHERE_RADIUS: sphere_radius <= cfg_data;
        REG_CENTRE_X:      centre_x      <= signed'(cfg_data);
        REG_CENTRE_Y:      centre_y      <= signed'(cfg_data);
        REG_CENTRE_Z:      centre_z      <= signed'(cfg_data);
        REG_BASE_INDEX:    base_index    <= cfg_data;
        default:           ;
      endcase
    end
  end

  logic [8:0] nr, ns, nr1;
  logic       adv;
  logic       bad_in;

  assign nr  = eff_count(ring_count);
  assign ns  = eff_count(section_count);
  assign nr1 = nr - 9'd1;
  assign in_ready = adv;

  // Range check per mode
  assign bad_in = mode ? ((9'(ring) + 9'd1 >= nr) || (section >= ns))
                       : ((9'(ring) >= nr) || (section > ns));

  // Input stage
  logic              b_valid, b_mode, b_bad;
  logic [8:0]        b_s;
  logic [16:0]       b_prod;
  logic [NUM_W-1:0]  n_th, n_ph, n_u, n_v;

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else if (adv) b_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_mode <= mode;
      b_bad  <= bad_in;
      b_s    <= section;
      b_prod <= 17'(ring) * (17'(ns) + 17'd1);
      n_th   <= (NUM_W'(section) << ANGLE_BITS) + NUM_W'(ns >> 1);
      n_ph   <= (NUM_W'(ring) << (ANGLE_BITS - 1)) + NUM_W'(nr1 >> 1);
      n_u    <= (NUM_W'(section) << 16) + NUM_W'(ns >> 1);
      n_v    <= (NUM_W'(ring) << 16) + NUM_W'(nr1 >> 1);
    end
  end

  // Dividers
  logic [QUO_W-1:0] q_th, q_ph, q_u, q_v;

  usm_div #(.NW(NUM_W), .QW(QUO_W), .DW(DEN_W)) u_div_th (
    .clk(clk), .en(adv), .num(n_th), .den(ns),  .quo(q_th));
  usm_div #(.NW(NUM_W), .QW(QUO_W), .DW(DEN_W)) u_div_ph (
    .clk(clk), .en(adv), .num(n_ph), .den(nr1), .quo(q_ph));
  usm_div #(.NW(NUM_W), .QW(QUO_W), .DW(DEN_W)) u_div_u (
    .clk(clk), .en(adv), .num(n_u),  .den(ns),  .quo(q_u));
  usm_div #(.NW(NUM_W), .QW(QUO_W), .DW(DEN_W)) u_div_v (
    .clk(clk), .en(adv), .num(n_v),  .den(nr1), .quo(q_v));

  // Sideband alongside the dividers, face base indices formed on entry
  side_t dv [0:QUO_W-1];
  side_t dv_in;
  logic [15:0] ps_in;

  assign ps_in = b_prod[15:0] + base_index + 16'(b_s);

  always_comb begin
    dv_in       = '0;
    dv_in.valid = b_valid;
    dv_in.mode  = b_mode;
    dv_in.bad   = b_bad;
    dv_in.ps    = ps_in;
    dv_in.cs    = ps_in + 16'(ns) + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QUO_W; i++) dv[i] <= '0;
    end else if (adv) begin
      dv[0] <= dv_in;
      for (int i = 1; i < QUO_W; i++) dv[i] <= dv[i-1];
    end
  end

  // Sideband alongside the trig pipeline, texture pair attached
  side_t tv [0:TRIG_LAT-1];
  side_t tv_in;

  always_comb begin
    tv_in       = dv[QUO_W-1];
    tv_in.tex_u = q_u;
    tv_in.tex_v = q_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TRIG_LAT; i++) tv[i] <= '0;
    end else if (adv) begin
      tv[0] <= tv_in;
      for (int i = 1; i < TRIG_LAT; i++) tv[i] <= tv[i-1];
    end
  end

  logic signed [15:0] t_px, t_py, t_pz, t_nx, t_ny, t_nz;

  usm_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig (
    .clk(clk), .en(adv),
    .theta(q_th[ANGLE_BITS-1:0]), .phi(q_ph[ANGLE_BITS-1:0]),
    .radius(sphere_radius), .cx(centre_x), .cy(centre_y), .cz(centre_z),
    .pos_x(t_px), .pos_y(t_py), .pos_z(t_pz),
    .norm_x(t_nx), .norm_y(t_ny), .norm_z(t_nz));

  usm_out u_out (
    .clk(clk), .rst(rst), .side(tv[TRIG_LAT-1]),
    .in_pos_x(t_px), .in_pos_y(t_py), .in_pos_z(t_pz),
    .in_norm_x(t_nx), .in_norm_y(t_ny), .in_norm_z(t_nz),
    .adv(adv), .out_valid(out_valid), .out_ready(out_ready),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
    .tex_u(tex_u), .tex_v(tex_v), .vertex_index(vertex_index),
    .last(last), .bad_request(bad_request));

endmodule

@@ tb/uv_sphere_mesh_point_generator_top_tb.sv @@
// ---------------------------------------------------------------------------
// uv_sphere_mesh_point_generator_top_tb
// Self-checking bench for the UV sphere point generator. Requests go in from
// a queue, and an in-bench model predicts the results of each accepted
// request. Phases change the register settings, including the extremes, and
// the sender and receiver idle patterns.
// ---------------------------------------------------------------------------
module uv_sphere_mesh_point_generator_top_tb import usm_pkg::*; ();

  localparam logic [2:0] REG_UNUSED = 3'd7;  // index past the register map
  localparam int         DRAIN_CYCLES = 40;  // pipeline depth plus margin
  localparam int         WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic              mode;
    logic [7:0]        ring;
    logic [8:0]        section;
  } request_t;

  typedef struct {
    logic signed [15:0] px, py, pz, nx, ny, nz;
    logic [16:0]        tu, tv;
    logic [15:0]        vidx;
    logic               last, bad;
  } point_t;

  logic               clk, rst;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               in_valid, in_ready;
  logic               mode;
  logic [7:0]         ring;
  logic [8:0]         section;
  logic               out_valid, out_ready;
  logic signed [15:0] pos_x, pos_y, pos_z, norm_x, norm_y, norm_z;
  logic [16:0]        tex_u, tex_v;
  logic [15:0]        vertex_index;
  logic               last, bad_request;

  uv_sphere_mesh_point_generator_top i_dut (.*);

  // Shadow registers
  logic [8:0]         sh_rings, sh_sections;
  logic [15:0]        sh_radius, sh_base;
  logic signed [15:0] sh_cx, sh_cy, sh_cz;

  request_t pending_requests[$];
  point_t   expected_points[$];
  int       sender_idle_pct, receiver_stall_pct;
  int       fail_count, quiet_cycles;

  // Clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint clamp_count(input logic [8:0] c);
    longint v;
    v = c;
    if (v > 256) v = 256;
    if (v < 3) v = 3;
    return v;
  endfunction

  // Quarter-wave sine, Q1.14, Q30 Taylor series
  function automatic longint quarter_sine(input longint unsigned x);
    longint unsigned a, a2, term;
    longint          sum, r;
    a = (x * 64'd3373259426 + 1024) / 2048;
    a2 = (a * a) >> 30;
    term = a;
    sum = longint'(a);
    for (int k = 1; k <= 7; k++) begin
      term = ((term * a2) >> 30) / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    r = (sum + 32768) / 65536;
    if (r > 16384) r = 16384;
    return r;
  endfunction

  function automatic longint sine_of(input longint unsigned t);
    longint unsigned x;
    t = t & 4095;
    x = t & 1023;
    case (t >> 10)
      0: return quarter_sine(x);
      1: return quarter_sine(1024 - x);
      2: return -quarter_sine(x);
      default: return -quarter_sine(1024 - x);
    endcase
  endfunction

  function automatic longint rnd14(input longint p);
    return (p + 8192) >>> 14;
  endfunction

  function automatic logic signed [15:0] clip16(input longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Expected results of one request under the current settings
  task automatic predict_points(input request_t q);
    point_t  pt;
    longint  nr, ns, r, s, theta, phi, sp, nx, ny, nz, rad, p, c;
    longint  idx[6];
    nr = clamp_count(sh_rings);
    ns = clamp_count(sh_sections);
    r = q.ring;
    s = q.section;
    pt = '{default: '0};
    pt.last = 1'b1;
    if (q.mode == 1'b0) begin
      if (r >= nr || s > ns) begin
        pt.bad = 1'b1;
      end else begin
        rad = sh_radius;
        theta = ((s * 4096 + ns / 2) / ns) & 4095;
        phi = (r * 2048 + (nr - 1) / 2) / (nr - 1);
        sp = sine_of(phi);
        ny = -sine_of(phi + 1024);
        nx = rnd14(sine_of(theta) * sp);
        nz = rnd14(sine_of(theta + 1024) * sp);
        pt.px = clip16(rnd14(rad * nx) + sh_cx);
        pt.py = clip16(rnd14(rad * ny) + sh_cy);
        pt.pz = clip16(rnd14(rad * nz) + sh_cz);
        pt.nx = nx[15:0];
        pt.ny = ny[15:0];
        pt.nz = nz[15:0];
        pt.tu = 17'((s * 65536 + ns / 2) / ns);
        pt.tv = 17'((r * 65536 + (nr - 1) / 2) / (nr - 1));
      end
      expected_points = {expected_points, pt};
    end else if (r + 1 >= nr || s >= ns) begin
      pt.bad = 1'b1;
      expected_points = {expected_points, pt};
    end else begin
      p = r * (ns + 1) + sh_base;
      c = p + ns + 1;
      idx = '{c + s, p + s, c + s + 1, c + s + 1, p + s, p + s + 1};
      for (int i = 0; i < 6; i++) begin
        pt.vidx = idx[i][15:0];
        pt.last = (i == 5);
        expected_points = {expected_points, pt};
      end
    end
  endtask

  // Request driver; predicts each request as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_points('{mode, ring, section});
      if (!in_valid || in_ready) begin
        if (pending_requests.size() > 0 &&
            $urandom_range(99) >= sender_idle_pct) begin
          request_t q;
          q = pending_requests.pop_front();
          in_valid <= 1'b1;
          mode <= q.mode;
          ring <= q.ring;
          section <= q.section;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input longint e, input longint a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      fail_count++;
    end
  endtask

  // Result monitor and receiver stall
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          point_t e;
          e = expected_points.pop_front();
          check_field("pos_x", e.px, pos_x);
          check_field("pos_y", e.py, pos_y);
          check_field("pos_z", e.pz, pos_z);
          check_field("norm_x", e.nx, norm_x);
          check_field("norm_y", e.ny, norm_y);
          check_field("norm_z", e.nz, norm_z);
          check_field("tex_u", e.tu, tex_u);
          check_field("tex_v", e.tv, tex_v);
          check_field("vertex_index", e.vidx, vertex_index);
          check_field("last", e.last, last);
          check_field("bad_request", e.bad, bad_request);
        end
      end
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Watchdog: cycles with work outstanding but no transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (!in_valid && pending_requests.size() == 0 &&
         expected_points.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("uv_sphere_mesh_point_generator_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      REG_RING_COUNT:    sh_rings = v[8:0];
      REG_SECTION_COUNT: sh_sections = v[8:0];
      REG_SPHERE_RADIUS: sh_radius = v;
      REG_CENTRE_X:      sh_cx = v;
      REG_CENTRE_Y:      sh_cy = v;
      REG_CENTRE_Z:      sh_cz = v;
      REG_BASE_INDEX:    sh_base = v;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (pending_requests.size() > 0 || in_valid || expected_points.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_request(input logic m, input int r, input int s);
    pending_requests = {pending_requests, request_t'{m, 8'(r), 9'(s)}};
  endtask

  // Grid-edge and out-of-grid requests for the current settings
  task automatic add_directed();
    int nr, ns;
    nr = int'(clamp_count(sh_rings));
    ns = int'(clamp_count(sh_sections));
    add_request(1'b0, 0, 0);
    add_request(1'b0, nr - 1, ns);
    add_request(1'b0, nr / 2, ns / 4);
    add_request(1'b0, nr, 0);
    add_request(1'b0, 0, ns + 1);
    add_request(1'b0, 255, 511);
    add_request(1'b1, 0, 0);
    add_request(1'b1, nr - 2, ns - 1);
    add_request(1'b1, nr - 1, 0);
    add_request(1'b1, 0, ns);
    add_request(1'b1, 255, 511);
  endtask

  // Mostly in-grid requests, some with the ring outside, a few anywhere
  task automatic add_random(input int n);
    int nr, ns, sel;
    nr = int'(clamp_count(sh_rings));
    ns = int'(clamp_count(sh_sections));
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 85)
        add_request(1'($urandom_range(1)), $urandom_range(nr - 1), $urandom_range(ns));
      else if (sel < 93)
        add_request(1'($urandom_range(1)), $urandom_range(nr, 255), $urandom_range(511));
      else
        add_request(1'($urandom_range(1)), $urandom_range(255), $urandom_range(511));
    end
  endtask

  task automatic load_settings(input int rc, input int sc, input int rad,
                               input int cx, input int cy, input int cz, input int base);
    write_reg(REG_RING_COUNT, 16'(rc));
    write_reg(REG_SECTION_COUNT, 16'(sc));
    write_reg(REG_SPHERE_RADIUS, 16'(rad));
    write_reg(REG_CENTRE_X, 16'(cx));
    write_reg(REG_CENTRE_Y, 16'(cy));
    write_reg(REG_CENTRE_Z, 16'(cz));
    write_reg(REG_BASE_INDEX, 16'(base));
    write_reg(REG_UNUSED, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  int idle_pattern[4][2] = '{'{0, 0}, '{85, 0}, '{0, 85}, '{22, 22}};

  // Stimulus sequence
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    mode = 1'b0;
    ring = '0;
    section = '0;
    out_ready = 1'b0;
    fail_count = 0;
    quiet_cycles = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    sh_rings = 9'd16;
    sh_sections = 9'd16;
    sh_radius = 16'd256;
    sh_cx = '0;
    sh_cy = '0;
    sh_cz = '0;
    sh_base = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset defaults
    add_directed();
    add_random(40);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      sender_idle_pct = idle_pattern[ph % 4][0];
      receiver_stall_pct = idle_pattern[ph % 4][1];
      case (ph)
        0: load_settings(256, 256, 65535, 32767, -32768, 32767, 65535);
        1: load_settings(0, 1, 0, -32768, 32767, -32768, 0);
        2: load_settings(2, 511, 65535, -32768, -32768, -32768, 65000);
        3: load_settings(3, 3, 32768, 1000, -1000, 0, 12345);
        default: load_settings($urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom);
      endcase
      add_directed();
      add_random(45);
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("uv_sphere_mesh_point_generator_top regression: pass");
    end else begin
      $display("uv_sphere_mesh_point_generator_top regression: fail");
    end
    $finish;
  end

endmodule
